/* rtl/chained_led_matrix_frame_and_scan_top_assert.svh */
// assertion macros for the led matrix frame and scan block
`ifndef CHAINED_LED_MATRIX_FRAME_AND_SCAN_TOP_ASSERT_SVH
`define CHAINED_LED_MATRIX_FRAME_AND_SCAN_TOP_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define CLMFS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("clmfs assertion failed");

// condition in this cycle implies consequence in the next cycle
`define CLMFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("clmfs assertion failed");

`endif

/* rtl/clmfs_pkg.sv */
// shared types and constants for the led matrix frame and scan block
package clmfs_pkg;

    localparam int BYTE_W    = 8;
    localparam int COL_OUT_W = 3;
    localparam int OUT_DW    = 24;

    localparam logic [BYTE_W-1:0] GAP_RESET = 8'd4;

    // input item kinds carried in tuser
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // result kinds carried in tuser
    localparam logic OUT_SCAN = 1'b0;
    localparam logic OUT_FWD  = 1'b1;

    // result waiting for the frame store read data
    typedef struct packed {
        logic                 kind;
        logic [COL_OUT_W-1:0] col;
        logic [BYTE_W-1:0]    fwd;
        logic                 row_valid;
    } t_s1;

endpackage

/* rtl/clmfs_ram.sv */
// generic single write port ram with registered read
module clmfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/chained_led_matrix_frame_and_scan_top.sv */
// Daisy-chained LED matrix node: frame capture, downstream forwarding, column scan.
// A result reaches the master side through the stage one register and then the output register.
// Throughput: one input transaction per cycle while the master side takes results,
//   set by the registered read of the frame store ram feeding a two-register output.
// Reset (synchronous, active low) clears counters, sync flag and the per-entry valid
//   bits of the frame store at once, so the store reads as zero; no clearing pass.
module chained_led_matrix_frame_and_scan_top #(
    parameter int MATRIX_SIZE = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration: gap_ticks
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [clmfs_pkg::BYTE_W-1:0] i_cfg_data,
    // input stream
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [7:0]                   i_s_tdata,  // [7:0] rx_byte
    input  logic                         i_s_tuser,  // [0] req_type
    // output stream
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [clmfs_pkg::OUT_DW-1:0] o_m_tdata,  // [2:0] active_column,
                                                     // [10:3] row_bits, [18:11] fwd_byte,
                                                     // [23:19] zero
    output logic                         o_m_tuser   // [0] out_kind
);

    import clmfs_pkg::*;

    localparam int CW = $clog2(MATRIX_SIZE);
    localparam int WW = $clog2(MATRIX_SIZE + 1);

    logic [BYTE_W-1:0]      r_gap;
    logic [BYTE_W-1:0]      r_idle, n_idle;
    logic [WW-1:0]          r_widx, n_widx;
    logic                   r_synced, n_synced;
    logic [CW-1:0]          r_col, n_col;
    logic [MATRIX_SIZE-1:0] r_valid;

    logic                   r_s1_valid;
    t_s1                    r_s1, n_s1;
    logic                   r_out_valid;
    logic                   r_out_kind;
    logic [OUT_DW-1:0]      r_out_data;

    logic                   in_acc;
    logic                   is_tick;
    logic [BYTE_W:0]        idle_next;
    logic                   gap_hit;
    logic [CW-1:0]          col_next;
    logic [CW+2:0]          col_ext;
    logic                   store_ok;
    logic                   ram_we;
    logic                   ram_re;
    logic                   res_valid;
    logic                   out_free;
    logic [BYTE_W-1:0]      ram_rdata;
    logic [BYTE_W-1:0]      s1_row;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_s_tready  = !r_s1_valid || out_free;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign is_tick     = (i_s_tuser == REQ_TICK);

    // gap detection and column step
    assign idle_next = {1'b0, r_idle} + 9'd1;
    assign gap_hit   = (idle_next >= {1'b0, r_gap});
    assign col_next  = (r_col == CW'(MATRIX_SIZE - 1)) ? '0 : r_col + 1'b1;
    assign col_ext   = {3'b000, col_next};

    // frame store access decisions
    assign store_ok  = r_synced && (r_widx < WW'(MATRIX_SIZE));
    assign ram_we    = in_acc && !is_tick && store_ok;
    assign ram_re    = in_acc && is_tick;
    assign res_valid = in_acc && (is_tick || (r_synced && !store_ok));

    // next control state for an accepted transaction
    always_comb begin
        n_idle   = r_idle;
        n_widx   = r_widx;
        n_synced = r_synced;
        n_col    = r_col;
        if (in_acc) begin
            if (is_tick) begin
                n_col = col_next;
                if (gap_hit) begin
                    n_idle   = '0;
                    n_widx   = '0;
                    n_synced = 1'b1;
                end else begin
                    n_idle = idle_next[BYTE_W-1:0];
                end
            end else begin
                n_idle = '0;
                if (store_ok) begin
                    n_widx = r_widx + 1'b1;
                end
            end
        end
    end

    // stage one payload
    always_comb begin
        n_s1.kind      = is_tick ? OUT_SCAN : OUT_FWD;
        n_s1.col       = is_tick ? col_ext[COL_OUT_W-1:0] : '0;
        n_s1.fwd       = is_tick ? '0 : i_s_tdata;
        n_s1.row_valid = is_tick && r_valid[col_next];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap    <= GAP_RESET;
            r_idle   <= '0;
            r_widx   <= '0;
            r_synced <= 1'b0;
            r_col    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_gap <= i_cfg_data;
            end
            r_idle   <= n_idle;
            r_widx   <= n_widx;
            r_synced <= n_synced;
            r_col    <= n_col;
        end
    end

    // per-entry written flags, store reads as zero until written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ram_we) begin
            r_valid[r_widx[CW-1:0]] <= 1'b1;
        end
    end

    // frame store
    clmfs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MATRIX_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_widx[CW-1:0]),
        .i_wdata (i_s_tdata),
        .i_re    (ram_re),
        .i_raddr (col_next),
        .o_rdata (ram_rdata)
    );

    // stage one: waits for the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && res_valid) begin
            r_s1 <= n_s1;
        end
    end

    assign s1_row = r_s1.row_valid ? ram_rdata : '0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_kind <= r_s1.kind;
            r_out_data <= {5'b00000, r_s1.fwd, s1_row, r_s1.col};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = r_out_data;

    // checks
    `include "chained_led_matrix_frame_and_scan_top_assert.svh"

    `CLMFS_ASSERT_NOW(a_fwd_zero_scan, o_m_tvalid && (o_m_tuser == OUT_FWD), o_m_tdata[10:0] == 11'd0)
    `CLMFS_ASSERT_NOW(a_store_synced, ram_we, r_synced && !ram_re)
    `CLMFS_ASSERT_NOW(a_widx_bound, 1'b1, r_widx <= WW'(MATRIX_SIZE))
    `CLMFS_ASSERT_NEXT(a_tick_reaches_s1, ram_re, r_s1_valid && (r_s1.kind == OUT_SCAN))

endmodule

/* tb/sv/chained_led_matrix_frame_and_scan_top_test.sv */
// self-checking testbench for the chained led matrix frame capture and column scan node
module chained_led_matrix_frame_and_scan_top_test;
    import clmfs_pkg::*;

    localparam int MATRIX       = 8;
    localparam int QUIET_CYCLES = 8;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_ITEMS  = 60;
    localparam int NUM_PHASES   = 6;

    // expected result of one transaction on the master side
    typedef struct packed {
        logic              kind;
        logic [2:0]        col;
        logic [BYTE_W-1:0] row;
        logic [BYTE_W-1:0] fwd;
    } scan_out_t;

    // where a directed row takes its expectation from
    typedef enum logic [1:0] {
        FROM_PREDICTOR,
        NO_RESULT,
        GIVEN
    } exp_src_e;

    typedef struct {
        logic              kind;
        logic [BYTE_W-1:0] rx;
        exp_src_e          src;
        scan_out_t         given;
    } stim_row_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [BYTE_W-1:0] cfg_data  = '0;

    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = '0;
    logic              s_tuser  = REQ_TICK;

    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_DW-1:0] m_tdata;
    logic              m_tuser;

    // predictor state
    logic [BYTE_W-1:0] pixel_store [MATRIX];
    int                fill_idx;
    int                tick_run;
    bit                armed;
    logic [2:0]        scan_col;
    logic [BYTE_W-1:0] gap_len;

    scan_out_t pending_out [$];
    stim_row_t stim_rows [$];
    scan_out_t seen_out;
    scan_out_t want_out;

    int fault_count = 0;
    int item_total  = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left   = 0;
    bit hold_req    = 1'b0;
    bit hold_ack    = 1'b0;

    chained_led_matrix_frame_and_scan_top #(
        .MATRIX_SIZE(MATRIX)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),  // [7:0] rx_byte
        .i_s_tuser  (s_tuser),  // [0] req_type
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),  // [2:0] active_column, [10:3] row_bits, [18:11] fwd_byte
        .o_m_tuser  (m_tuser)   // [0] out_kind
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // advance the node state by one item, return 1 when a result comes out
    function automatic bit predict_scan(input logic kind, input logic [BYTE_W-1:0] rx,
                                        output scan_out_t res);
        res = '0;
        if (kind == REQ_TICK) begin
            // a run of ticks reaching the gap length closes the frame
            if (tick_run + 1 >= int'(gap_len)) begin
                fill_idx = 0;
                tick_run = 0;
                armed    = 1'b1;
            end else begin
                tick_run = tick_run + 1;
            end
            scan_col = scan_col + 3'd1;
            res.kind = OUT_SCAN;
            res.col  = scan_col;
            res.row  = pixel_store[scan_col];
            return 1'b1;
        end
        tick_run = 0;
        if (!armed)
            return 1'b0;
        if (fill_idx < MATRIX) begin
            pixel_store[fill_idx] = rx;
            fill_idx = fill_idx + 1;
            return 1'b0;
        end
        res.kind = OUT_FWD;
        res.fwd  = rx;
        return 1'b1;
    endfunction

    // offer one item until the node takes it, then record what it should produce
    task automatic send_item(input logic kind, input logic [BYTE_W-1:0] rx,
                             input exp_src_e src, input scan_out_t given);
        scan_out_t res;
        bit        has;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= rx;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        has = predict_scan(kind, rx, res);
        item_total = item_total + 1;
        case (src)
            FROM_PREDICTOR: if (has) pending_out.push_back(res);
            GIVEN:          pending_out.push_back(given);
            default:        ;
        endcase
    endtask

    // stop offering, wait for all results, then let the pipeline settle
    task automatic quiet_down();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_out.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited = waited + 1;
        end
        if (pending_out.size() != 0) begin
            $error("results never arrived: %0d still expected", pending_out.size());
            fault_count = fault_count + 1;
            pending_out.delete();
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // write gap_ticks over the config channel
    task automatic load_gap(input logic [BYTE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
        gap_len = value;
    endtask

    task automatic add_row(input logic kind, input logic [BYTE_W-1:0] rx, input exp_src_e src,
                           input logic okind, input logic [2:0] col,
                           input logic [BYTE_W-1:0] row, input logic [BYTE_W-1:0] fwd);
        stim_row_t r;
        r.kind  = kind;
        r.rx    = rx;
        r.src   = src;
        r.given = '{kind: okind, col: col, row: row, fwd: fwd};
        stim_rows.push_back(r);
    endtask

    // one frame with random content, or a short run of noise
    task automatic gen_burst(input bit full_gap);
        int glen;
        int nt;
        int nb;
        int i;
        glen = (gap_len == 0) ? 1 : int'(gap_len);
        if (full_gap || $urandom_range(0, 99) < 70) begin
            nt = glen;
            if (!full_gap && glen > 32 && $urandom_range(0, 3) != 0)
                nt = $urandom_range(0, glen - 1);
            for (i = 0; i < nt; i++)
                send_item(REQ_TICK, 8'($urandom), FROM_PREDICTOR, '0);
            nb = $urandom_range(1, 12);
            for (i = 0; i < nb; i++) begin
                // a stray tick inside the frame
                if ($urandom_range(0, 99) < 15)
                    send_item(REQ_TICK, 8'($urandom), FROM_PREDICTOR, '0);
                send_item(REQ_BYTE, 8'($urandom_range(0, 255)), FROM_PREDICTOR, '0);
            end
        end else begin
            nt = $urandom_range(1, 6);
            for (i = 0; i < nt; i++)
                send_item(1'($urandom), 8'($urandom), FROM_PREDICTOR, '0);
        end
    endtask

    // receiver: random back-pressure plus a long hold on request
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // compare each output transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            seen_out = '{kind: m_tuser, col: m_tdata[2:0], row: m_tdata[10:3],
                         fwd: m_tdata[18:11]};
            if (pending_out.size() == 0) begin
                $error("unexpected result kind=%0d col=%0d row=%02h fwd=%02h",
                       seen_out.kind, seen_out.col, seen_out.row, seen_out.fwd);
                fault_count = fault_count + 1;
            end else begin
                want_out = pending_out.pop_front();
                if (seen_out.kind != want_out.kind) begin
                    $error("out_kind expected %0d got %0d", want_out.kind, seen_out.kind);
                    fault_count = fault_count + 1;
                end
                if (seen_out.col != want_out.col) begin
                    $error("active_column expected %0d got %0d", want_out.col, seen_out.col);
                    fault_count = fault_count + 1;
                end
                if (seen_out.row != want_out.row) begin
                    $error("row_bits expected %02h got %02h", want_out.row, seen_out.row);
                    fault_count = fault_count + 1;
                end
                if (seen_out.fwd != want_out.fwd) begin
                    $error("fwd_byte expected %02h got %02h", want_out.fwd, seen_out.fwd);
                    fault_count = fault_count + 1;
                end
            end
            if (m_tdata[OUT_DW-1:19] != '0) begin
                $error("tdata padding expected 0 got %h", m_tdata[OUT_DW-1:19]);
                fault_count = fault_count + 1;
            end
        end
    end

    // main sequence
    initial begin
        logic [BYTE_W-1:0] phase_gap [NUM_PHASES];
        int                ph;
        int                phase_start;
        int                k;

        for (k = 0; k < MATRIX; k++)
            pixel_store[k] = '0;
        fill_idx = 0;
        tick_run = 0;
        armed    = 1'b0;
        scan_col = '0;
        gap_len  = GAP_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bytes before the first gap are dropped, the store reads zero
        add_row(REQ_BYTE, 8'hFF, NO_RESULT, OUT_SCAN, 3'd0, 8'h00, 8'h00);
        add_row(REQ_BYTE, 8'h00, NO_RESULT, OUT_SCAN, 3'd0, 8'h00, 8'h00);
        add_row(REQ_TICK, 8'h00, GIVEN, OUT_SCAN, 3'd1, 8'h00, 8'h00);
        add_row(REQ_TICK, 8'hFF, GIVEN, OUT_SCAN, 3'd2, 8'h00, 8'h00);
        // a byte restarts the idle run
        add_row(REQ_BYTE, 8'h5A, NO_RESULT, OUT_SCAN, 3'd0, 8'h00, 8'h00);
        add_row(REQ_TICK, 8'h00, GIVEN, OUT_SCAN, 3'd3, 8'h00, 8'h00);
        add_row(REQ_TICK, 8'h00, GIVEN, OUT_SCAN, 3'd4, 8'h00, 8'h00);
        add_row(REQ_TICK, 8'h00, GIVEN, OUT_SCAN, 3'd5, 8'h00, 8'h00);
        add_row(REQ_TICK, 8'h00, GIVEN, OUT_SCAN, 3'd6, 8'h00, 8'h00);
        // first frame fills the store
        add_row(REQ_BYTE, 8'h00, NO_RESULT, OUT_SCAN, 3'd0, 8'h00, 8'h00);
        add_row(REQ_BYTE, 8'hFF, NO_RESULT, OUT_SCAN, 3'd0, 8'h00, 8'h00);
        add_row(REQ_BYTE, 8'h01, NO_RESULT, OUT_SCAN, 3'd0, 8'h00, 8'h00);
        add_row(REQ_BYTE, 8'h80, NO_RESULT, OUT_SCAN, 3'd0, 8'h00, 8'h00);
        add_row(REQ_BYTE, 8'h55, NO_RESULT, OUT_SCAN, 3'd0, 8'h00, 8'h00);
        add_row(REQ_BYTE, 8'hAA, NO_RESULT, OUT_SCAN, 3'd0, 8'h00, 8'h00);
        add_row(REQ_BYTE, 8'h0F, NO_RESULT, OUT_SCAN, 3'd0, 8'h00, 8'h00);
        add_row(REQ_BYTE, 8'hF0, NO_RESULT, OUT_SCAN, 3'd0, 8'h00, 8'h00);
        // store full, bytes go downstream
        add_row(REQ_BYTE, 8'hFF, GIVEN, OUT_FWD, 3'd0, 8'h00, 8'hFF);
        add_row(REQ_BYTE, 8'h00, GIVEN, OUT_FWD, 3'd0, 8'h00, 8'h00);
        // scan the stored frame across the column wrap
        for (k = 0; k < 6; k++)
            add_row(REQ_TICK, 8'h00, FROM_PREDICTOR, OUT_SCAN, 3'd0, 8'h00, 8'h00);

        foreach (stim_rows[k])
            send_item(stim_rows[k].kind, stim_rows[k].rx, stim_rows[k].src, stim_rows[k].given);

        // random phases over several gap lengths, extremes included
        phase_gap[0] = 8'd1;
        phase_gap[1] = 8'd255;
        phase_gap[2] = 8'd0;
        phase_gap[3] = 8'd2;
        phase_gap[4] = 8'($urandom_range(3, 12));
        phase_gap[5] = 8'd6;

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            quiet_down();
            case (ph / 2)
                0: begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 84;
                end
                1: begin
                    tx_idle_pct = 84;
                    rx_idle_pct = 20;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            load_gap(phase_gap[ph]);
            // long receiver hold while items keep coming
            if (ph == 4)
                hold_req <= ~hold_req;
            phase_start = item_total;
            gen_burst(1'b1);
            while (item_total - phase_start < PHASE_ITEMS)
                gen_burst(1'b0);
        end

        quiet_down();
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
